@@ sv/lcr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcr_pkg: shared types and constants
// Field widths of the access and result ports and the result record.
// ----------------------------------------------------------------------------
package lcr_pkg;

	localparam int ADDR_PORT_W = 32;
	localparam int CFG_W       = 5;

	localparam logic [CFG_W-1:0] WAYS_RESET = 5'd16;

	typedef struct packed {
		logic                   hit;
		logic                   evicted;
		logic [ADDR_PORT_W-1:0] evicted_address;
	} result_t;

endpackage

@@ sv/lcr_capacity_reg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcr_capacity_reg: capacity register
// Holds ways_in_use and presents it clamped to the range 1 to MAX_ENTRIES.
// ----------------------------------------------------------------------------
module lcr_capacity_reg #(
	parameter int MAX_ENTRIES = 16,
	parameter int CNT_W       = 5
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [lcr_pkg::CFG_W-1:0] ways_in_use,
	output logic [CNT_W-1:0]          cap
);
	import lcr_pkg::*;

	logic [CFG_W-1:0] ways_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ways_q <= WAYS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			ways_q <= ways_in_use;
		end
	end

	// zero acts as one, anything above the store size acts as full size
	always_comb begin
		if (ways_q == '0) begin
			cap = CNT_W'(1);
		end else if (32'(ways_q) > 32'(MAX_ENTRIES)) begin
			cap = CNT_W'(MAX_ENTRIES);
		end else begin
			cap = CNT_W'(ways_q);
		end
	end

endmodule

@@ sv/lcr_tag_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcr_tag_store: recency-ordered tag store
// Parallel tag compare over the valid entries, eviction of the least-recent
// entry, and a recency shift with the new tag placed at the front.
// ----------------------------------------------------------------------------
module lcr_tag_store #(
	parameter int MAX_ENTRIES = 16,
	parameter int ADDR_BITS   = 32,
	parameter int CNT_W       = 5
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   advance,
	input  logic [ADDR_BITS-1:0]   tag,
	input  logic [CNT_W-1:0]       cap,
	output lcr_pkg::result_t       result
);
	import lcr_pkg::*;

	localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

	logic [ADDR_BITS-1:0]   entry_q [MAX_ENTRIES];
	logic [CNT_W-1:0]       fill_q;
	logic [MAX_ENTRIES-1:0] match;
	logic [MAX_ENTRIES-1:0] shift;
	logic                   found;
	logic                   evict;
	logic [CNT_W-1:0]       fill_dec;
	logic [IDX_W-1:0]       ev_idx;
	logic [ADDR_BITS-1:0]   ev_tag;

	always_comb begin
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			match[i] = (CNT_W'(i) < fill_q) && (entry_q[i] == tag);
		end
	end

	// an entry moves back one place unless the hit lies in front of it
	always_comb begin
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			shift[i] = ~|(match & ~({MAX_ENTRIES{1'b1}} << i));
		end
	end

	assign found    = |match;
	assign evict    = !found && (fill_q >= cap);
	assign fill_dec = fill_q - CNT_W'(1);
	assign ev_idx   = fill_dec[IDX_W-1:0];
	assign ev_tag   = entry_q[ev_idx];

	always_comb begin
		result.hit             = found;
		result.evicted         = evict;
		result.evicted_address = evict ? ADDR_PORT_W'(ev_tag) : '0;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			entry_q[0] <= tag;
			for (int i = 1; i < MAX_ENTRIES; i++) begin
				if (shift[i]) begin
					entry_q[i] <= entry_q[i-1];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (advance && !found && !evict) begin
			fill_q <= fill_q + CNT_W'(1);
		end
	end

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(fill_q) <= 32'(MAX_ENTRIES))
		else $error("fill count above store size");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !found && !evict |=> fill_q == $past(fill_q) + CNT_W'(1))
		else $error("miss without eviction did not grow the fill count");

	a_hit_keeps_fill: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (found || evict) |=> $stable(fill_q))
		else $error("hit or eviction changed the fill count");

	a_front_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> entry_q[0] == $past(tag))
		else $error("accessed tag not placed at the most-recent position");

	a_evict_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		evict |-> (fill_q != '0) && !found)
		else $error("eviction from an empty store or on a hit");
`endif

endmodule

@@ sv/lru_cache_replacement_unit.sv @@
`timescale 1ns / 1ps
// Result path: input register, then result register.
// Throughput: one address per cycle while out_stall is low; compare, eviction pick and recency shift
// all happen combinationally between the input register and the result register.
// Reset: fill count cleared (store empty), capacity 16 clamped to MAX_ENTRIES, no results
// pending; tag entries hold no reset value and are tracked by the fill count only.
// ----------------------------------------------------------------------------
// lru_cache_replacement_unit: fully associative LRU tag store
// Looks up each address, reports hit or miss and any evicted least-recent tag.
// ----------------------------------------------------------------------------
module lru_cache_replacement_unit #(
	parameter int MAX_ENTRIES = 16,
	parameter int ADDR_BITS   = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [lcr_pkg::ADDR_PORT_W-1:0] address,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            hit,
	output logic                            evicted,
	output logic [lcr_pkg::ADDR_PORT_W-1:0] evicted_address,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [lcr_pkg::CFG_W-1:0]       ways_in_use
);
	import lcr_pkg::*;

	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

	logic                 valid_s1;
	logic [ADDR_BITS-1:0] tag_s1;
	logic                 valid_s2;
	result_t              result_s2;
	result_t              result;
	logic [CNT_W-1:0]     cap;
	logic                 out_free;
	logic                 advance;

	lcr_capacity_reg #(
		.MAX_ENTRIES(MAX_ENTRIES),
		.CNT_W      (CNT_W)
	) u_cap (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.ways_in_use(ways_in_use),
		.cap        (cap)
	);

	lcr_tag_store #(
		.MAX_ENTRIES(MAX_ENTRIES),
		.ADDR_BITS  (ADDR_BITS),
		.CNT_W      (CNT_W)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.advance(advance),
		.tag    (tag_s1),
		.cap    (cap),
		.result (result)
	);

	// result register frees when empty or when its transfer completes this cycle
	assign out_free = !valid_s2 || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (out_free) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			tag_s1 <= ADDR_BITS'(address);
		end
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign out_valid       = valid_s2;
	assign hit             = result_s2.hit;
	assign evicted         = result_s2.evicted;
	assign evicted_address = result_s2.evicted_address;

endmodule

@@ test/lru_cache_replacement_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_cache_replacement_unit_test: self-checking bench for the LRU tag store
// Streams addresses through the cache under several capacity settings and
// idle/stall patterns. An in-bench recency list predicts hit, eviction and
// evicted tag per access, and the monitor compares each result in order.
// ----------------------------------------------------------------------------
module lru_cache_replacement_unit_test;

	import lcr_pkg::*;

	localparam int NUM_WAYS     = 16;
	localparam int LONG_HOLD    = 80;
	localparam int DRAIN_CYCLES = 4;
	localparam int CYCLE_LIMIT  = 400000;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	logic [ADDR_PORT_W-1:0] address = '0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic                   hit;
	logic                   evicted;
	logic [ADDR_PORT_W-1:0] evicted_address;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_W-1:0]       ways_in_use = WAYS_RESET;

	lru_cache_replacement_unit uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.address         (address),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.hit             (hit),
		.evicted         (evicted),
		.evicted_address (evicted_address),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.ways_in_use     (ways_in_use)
	);

	always #5 clk = ~clk;

	// recency list, index 0 is most recent
	logic [ADDR_PORT_W-1:0] lru_tags [NUM_WAYS];
	int                     lru_fill = 0;
	logic [CFG_W-1:0]       lru_ways = WAYS_RESET;

	logic [ADDR_PORT_W-1:0] pending_accesses [$];
	result_t                expected_results [$];

	int items_queued = 0;
	int items_accepted = 0;
	int cfg_writes = 0;
	int error_count = 0;
	int hits_seen = 0;
	int evictions_seen = 0;
	int cycle_count = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_requests = 0;
	int holds_served = 0;
	int hold_left = 0;
	bit access_taken = 1'b0;

	function automatic result_t lru_access(input logic [ADDR_PORT_W-1:0] tag);
		result_t res;
		int      cap;
		int      pos;
		bit      found;
		res = '0;
		cap = int'(lru_ways);
		found = 1'b0;
		pos = 0;
		if (cap < 1)
			cap = 1;
		if (cap > NUM_WAYS)
			cap = NUM_WAYS;
		for (int i = 0; i < lru_fill; i++) begin
			if (!found && lru_tags[i] == tag) begin
				found = 1'b1;
				pos = i;
			end
		end
		if (found) begin
			res.hit = 1'b1;
		end else begin
			if (lru_fill >= cap && lru_fill > 0) begin
				res.evicted = 1'b1;
				res.evicted_address = lru_tags[lru_fill-1];
				lru_fill--;
			end
			pos = lru_fill;
			if (lru_fill < NUM_WAYS)
				lru_fill++;
		end
		// shift everything above the slot one place toward the LRU end
		for (int i = pos; i > 0; i--) begin
			if (i < NUM_WAYS)
				lru_tags[i] = lru_tags[i-1];
		end
		lru_tags[0] = tag;
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [ADDR_PORT_W-1:0] got,
			input logic [ADDR_PORT_W-1:0] want);
		$display("[%0t] MISMATCH %s: got %08h, want %08h", $realtime, what, got, want);
		error_count++;
	endtask

	// monitor and predictor: sample everything at the rising edge
	always @(posedge clk) begin
		result_t want;
		access_taken <= arst_n && in_valid && !in_stall;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				lru_ways = ways_in_use;
				cfg_writes++;
			end
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result with nothing pending", evicted_address, '0);
				end else begin
					want = expected_results.pop_front();
					if (hit !== want.hit)
						report_mismatch("hit", ADDR_PORT_W'(hit), ADDR_PORT_W'(want.hit));
					if (evicted !== want.evicted)
						report_mismatch("evicted", ADDR_PORT_W'(evicted),
							ADDR_PORT_W'(want.evicted));
					if (evicted_address !== want.evicted_address)
						report_mismatch("evicted_address", evicted_address, want.evicted_address);
					hits_seen += int'(want.hit);
					evictions_seen += int'(want.evicted);
				end
			end
			if (in_valid && !in_stall) begin
				expected_results.insert(expected_results.size(), lru_access(address));
				items_accepted++;
			end
		end
	end

	// driver: advance to the next address only after a transfer
	always @(negedge clk) begin
		if (arst_n && (!in_valid || access_taken)) begin
			if (pending_accesses.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				address <= pending_accesses.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: random stalls, or a long hold when one is requested
	always @(negedge clk) begin
		if (hold_requests != holds_served) begin
			holds_served <= holds_served + 1;
			hold_left <= LONG_HOLD;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("FAILED: results differ");
			$finish;
		end
	end

	task automatic queue_access(input logic [ADDR_PORT_W-1:0] addr);
		pending_accesses.insert(pending_accesses.size(), addr);
		items_queued++;
	endtask

	task automatic wait_drained();
		while (items_accepted != items_queued || expected_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_ways(input logic [CFG_W-1:0] value);
		int target;
		target = cfg_writes + 1;
		@(negedge clk);
		cfg_valid <= 1'b1;
		ways_in_use <= value;
		wait (cfg_writes == target);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// mostly reuse a small working set so hits and evictions both occur
	task automatic run_phase(input logic [CFG_W-1:0] ways, input int count, input int pool_size,
			input int idle_pct, input int stall_in_pct, input bit long_hold);
		logic [ADDR_PORT_W-1:0] pool [$];
		int                     pick;
		wait_drained();
		write_ways(ways);
		send_idle_pct = idle_pct;
		stall_pct = stall_in_pct;
		for (int i = 0; i < pool_size; i++)
			pool.insert(pool.size(), $urandom);
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(99);
			if (pick < 80)
				queue_access(pool[$urandom_range(pool_size-1)]);
			else if (pick < 85)
				queue_access(pick[0] ? '1 : '0);
			else
				queue_access($urandom);
		end
		if (long_hold)
			hold_requests++;
	endtask

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset capacity: fill, hit at LRU and middle positions
		queue_access(32'h0000_0000);
		queue_access(32'hFFFF_FFFF);
		queue_access(32'h0000_0000);
		queue_access(32'h5555_5555);
		queue_access(32'hAAAA_AAAA);
		queue_access(32'hFFFF_FFFF);
		queue_access(32'hAAAA_AAAA);
		wait_drained();

		// capacity dropped below the fill: misses keep the fill count
		write_ways(5'd2);
		queue_access(32'h1234_5678);
		queue_access(32'h0000_0000);
		queue_access(32'hFFFF_FFFF);
		wait_drained();

		// zero capacity behaves as one way
		write_ways(5'd0);
		queue_access(32'h8000_0000);
		queue_access(32'h8000_0000);
		queue_access(32'h0000_0001);
		wait_drained();

		// oversized capacity clamps to the full store; fill it and evict once
		write_ways(5'd31);
		for (int i = 4; i < 17; i++)
			queue_access(32'h1 << i);

		run_phase(5'd4, 200, 6, 0, 0, 1'b1);
		run_phase(5'd16, 200, 20, 84, 0, 1'b0);
		run_phase(5'd0, 150, 3, 0, 84, 1'b0);
		run_phase(5'd31, 200, 20, 37, 37, 1'b0);
		run_phase(5'd12, 150, 14, 0, 0, 1'b0);
		run_phase(5'd3, 150, 5, 37, 37, 1'b1);
		run_phase(5'd17, 100, 18, 0, 84, 1'b0);
		run_phase(5'd1, 50, 2, 84, 84, 1'b0);
		wait_drained();
		repeat (10) @(negedge clk);

		$display("Checked %0d accesses across %0d capacity writes: %0d hits, %0d evictions",
			items_accepted, cfg_writes, hits_seen, evictions_seen);
		$display("Idle/stall mixes and %0d long output holds exercised, %0d mismatches",
			hold_requests, error_count);
		if (error_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
